>>> hdl/bbd_ptc_pkg.sv
package bbd_ptc_pkg;

  // default sizes
  localparam int unsigned RING_CELLS_DEF    = 1024;
  localparam int unsigned CHANNEL_COUNT_DEF = 2;
  localparam int unsigned SAMPLE_WIDTH_DEF  = 24;

  // fixed formats
  localparam int unsigned FRAC_BITS      = 20;
  localparam int unsigned READ_LEAD      = 4;
  localparam int unsigned RATE_W         = 24;
  localparam int unsigned PHASE_W        = 32;
  localparam int unsigned STEP_W         = 31;
  localparam int unsigned BASE_W         = 24;
  localparam int unsigned SPAN_W         = 25;
  localparam int unsigned DVSR_W         = 28;
  localparam int unsigned QUO_W          = 45;
  localparam int unsigned RATE_NUM_SHIFT = 43;

  // configuration port
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SPAN = 2'd2;

  localparam logic [STEP_W-1:0]        LFO_STEP_RST    = 31'd49318;
  localparam logic [BASE_W-1:0]        BASE_PERIOD_RST = 24'd4457056;
  localparam logic signed [SPAN_W-1:0] PERIOD_SPAN_RST = -25'sd3532270;

  localparam logic signed [RATE_W-1:0] Q420_MAX = 24'sh7FFFFF;
  localparam logic signed [RATE_W-1:0] Q420_MIN = 24'sh800000;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic phase;
    logic span;
    logic dvsr;
    logic rate_start;
    logic rate_take;
    logic ip_s;
    logic ip_r;
    logic stored_take;
    logic pitch_start;
    logic pitch_take;
    logic update;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic div_busy;
    logic d_zero;
    logic stored_pos;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/bbd_pitch_tracking_chorus_core.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   channel_i, sample_in_i
// out       output     out_valid_o / out_stall_i channel_out_o, sample_out_o
// cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// one item at a time: a new beat is taken only once the last one has been loaded
// into the output register, after the two radix-2 divisions (rate, then pitch) that share one
// divider, one bit a cycle; a zero divisor or a non-positive stored rate skips
// its division; a held output register adds its stall.
// after reset both rings are cleared, one entry a cycle, all CHANNEL_COUNT * RING_CELLS
// entries, with in_stall_o high; config writes are taken throughout.
// a result waits in the output register; the next beat is taken meanwhile.
module bbd_pitch_tracking_chorus_core #(
  parameter int unsigned RING_CELLS    = bbd_ptc_pkg::RING_CELLS_DEF,
  parameter int unsigned CHANNEL_COUNT = bbd_ptc_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned SAMPLE_WIDTH  = bbd_ptc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              channel_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              channel_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  input  logic                              cfg_we_i,
  input  logic [bbd_ptc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbd_ptc_pkg::CFG_W-1:0]     cfg_data_i
);

  bbd_ptc_pkg::cmd_t cmd;
  bbd_ptc_pkg::sts_t sts;

  // sequencer
  bbd_ptc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath with rings and divider
  bbd_ptc_dp #(
    .RING_CELLS    (RING_CELLS),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_o (channel_out_o),
    .sample_out_o  (sample_out_o)
  );

endmodule

>>> hdl/bbd_ptc_div.sv
module bbd_ptc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [bbd_ptc_pkg::QUO_W-1:0]      dividend_i,
  input  logic [bbd_ptc_pkg::DVSR_W-1:0]     divisor_i,
  output logic                               busy_o,
  output logic [bbd_ptc_pkg::QUO_W-1:0]      quotient_o
);

  localparam int unsigned QW  = bbd_ptc_pkg::QUO_W;
  localparam int unsigned DW  = bbd_ptc_pkg::DVSR_W;
  localparam int unsigned CNW = $clog2(QW + 1);

  logic [QW-1:0]  acc_q;
  logic [DW-1:0]  rem_q;
  logic [DW-1:0]  den_q;
  logic [CNW-1:0] cnt_q;
  logic           busy_q;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  // one restoring step per cycle
  assign trial = {rem_q, acc_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[QW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = acc_q;

endmodule

>>> hdl/bbd_ptc_ctrl.sv
module bbd_ptc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bbd_ptc_pkg::sts_t  sts_i,
  output bbd_ptc_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_PHASE  = 4'd2;
  localparam logic [3:0] ST_SPAN   = 4'd3;
  localparam logic [3:0] ST_DVSR   = 4'd4;
  localparam logic [3:0] ST_RSTART = 4'd5;
  localparam logic [3:0] ST_RWAIT  = 4'd6;
  localparam logic [3:0] ST_RTAKE  = 4'd7;
  localparam logic [3:0] ST_IPS    = 4'd8;
  localparam logic [3:0] ST_IPR    = 4'd9;
  localparam logic [3:0] ST_STAKE  = 4'd10;
  localparam logic [3:0] ST_PSTART = 4'd11;
  localparam logic [3:0] ST_PWAIT  = 4'd12;
  localparam logic [3:0] ST_PTAKE  = 4'd13;
  localparam logic [3:0] ST_UPDATE = 4'd14;
  localparam logic [3:0] ST_OUTQ   = 4'd15;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  assign in_stall_o = state_q != ST_IDLE;

  // sequencing of one item
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PHASE;
        end
      end
      ST_PHASE: begin
        cmd_o.phase = 1'b1;
        state_d     = ST_SPAN;
      end
      ST_SPAN: begin
        cmd_o.span = 1'b1;
        state_d    = ST_DVSR;
      end
      ST_DVSR: begin
        cmd_o.dvsr = 1'b1;
        state_d    = ST_RSTART;
      end
      ST_RSTART: begin
        if (sts_i.d_zero) begin
          state_d = ST_RTAKE;
        end else begin
          cmd_o.rate_start = 1'b1;
          state_d          = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (!sts_i.div_busy) state_d = ST_RTAKE;
      end
      ST_RTAKE: begin
        cmd_o.rate_take = 1'b1;
        state_d         = ST_IPS;
      end
      ST_IPS: begin
        cmd_o.ip_s = 1'b1;
        state_d    = ST_IPR;
      end
      ST_IPR: begin
        cmd_o.ip_r = 1'b1;
        state_d    = ST_STAKE;
      end
      ST_STAKE: begin
        cmd_o.stored_take = 1'b1;
        state_d           = ST_PSTART;
      end
      ST_PSTART: begin
        if (sts_i.stored_pos) begin
          cmd_o.pitch_start = 1'b1;
          state_d           = ST_PWAIT;
        end else begin
          state_d = ST_PTAKE;
        end
      end
      ST_PWAIT: begin
        if (!sts_i.div_busy) state_d = ST_PTAKE;
      end
      ST_PTAKE: begin
        cmd_o.pitch_take = 1'b1;
        state_d          = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUTQ;
      end
      ST_OUTQ: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

>>> hdl/bbd_ptc_dp.sv
module bbd_ptc_dp #(
  parameter int unsigned RING_CELLS    = bbd_ptc_pkg::RING_CELLS_DEF,
  parameter int unsigned CHANNEL_COUNT = bbd_ptc_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned SAMPLE_WIDTH  = bbd_ptc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bbd_ptc_pkg::cmd_t                    cmd_i,
  output bbd_ptc_pkg::sts_t                    sts_o,
  input  logic                                 cfg_we_i,
  input  logic [bbd_ptc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bbd_ptc_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                                 channel_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 channel_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out_o
);

  localparam int unsigned FB     = bbd_ptc_pkg::FRAC_BITS;
  localparam int unsigned RW     = bbd_ptc_pkg::RATE_W;
  localparam int unsigned PW     = bbd_ptc_pkg::PHASE_W;
  localparam int unsigned SW     = bbd_ptc_pkg::SPAN_W;
  localparam int unsigned DW     = bbd_ptc_pkg::DVSR_W;
  localparam int unsigned QW     = bbd_ptc_pkg::QUO_W;
  localparam int unsigned CELL_W = $clog2(RING_CELLS);
  localparam int unsigned RP_W   = CELL_W + FB;
  localparam int unsigned RPX_W  = RP_W + 2;
  localparam int unsigned DEPTH  = CHANNEL_COUNT * RING_CELLS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned IP_W   = ((SAMPLE_WIDTH > RW) ? SAMPLE_WIDTH : RW) + 1;
  localparam int unsigned IPX_W  = IP_W + 1;
  localparam int unsigned PROD_W = IP_W + FB + 1;
  localparam int unsigned SPP_W  = SW + PW + 1;

  localparam logic signed [RPX_W-1:0]  RING_LEN = RPX_W'(RING_CELLS) << FB;
  localparam logic signed [PROD_W-1:0] HALF_FB  = PROD_W'(1) << (FB - 1);
  localparam logic signed [SPP_W-1:0]  HALF_30  = SPP_W'(1) << 29;
  localparam logic signed [PW:0]       PH_ONE   = (PW + 1)'(1) << 30;
  localparam logic signed [PW:0]       PH_TWO   = (PW + 1)'(1) << 31;
  localparam logic [RW-1:0]            Q420_MAX_U = bbd_ptc_pkg::Q420_MAX;

  // configuration registers
  logic [bbd_ptc_pkg::STEP_W-1:0]     lfo_step_q;
  logic [bbd_ptc_pkg::BASE_W-1:0]     base_q;
  logic signed [SW-1:0]               span_q;

  // per-channel state
  logic signed [PW-1:0]  phase_q [CHANNEL_COUNT];
  logic [RP_W-1:0]       rp_q    [CHANNEL_COUNT];
  logic [CELL_W-1:0]     wp_q    [CHANNEL_COUNT];

  // ring memories
  logic signed [SAMPLE_WIDTH-1:0] mem_s_q [DEPTH];
  logic signed [RW-1:0]           mem_r_q [DEPTH];

  // item registers
  logic                           chan_q;
  logic [CH_W-1:0]                cidx_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [PW-1:0]                  lfo_q;
  logic signed [SPP_W-1:0]        spp_q;
  logic signed [DW-1:0]           d_q;
  logic signed [SAMPLE_WIDTH-1:0] rs_q, s0s_q, rd_q;
  logic signed [RW-1:0]           rr_q, s0r_q, stored_q, rate_q, pitch_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic                           out_valid_q;
  logic                           chan_out_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
  logic [ADDR_W-1:0]              clr_q;
  logic                           clr_done_q;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0] c,
                                                input logic [CELL_W-1:0] cix);
    addr_of = ADDR_W'(c) * ADDR_W'(RING_CELLS) + ADDR_W'(cix);
  endfunction

  function automatic logic signed [RW-1:0] sat_q(input logic neg, input logic [QW-1:0] q);
    logic signed [RW-1:0] r;
    if (!neg) r = (q > QW'(Q420_MAX_U)) ? bbd_ptc_pkg::Q420_MAX : RW'(q);
    else      r = (q > QW'(Q420_MAX_U) + QW'(1)) ? bbd_ptc_pkg::Q420_MIN : -RW'(q);
    return r;
  endfunction

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_step_q <= bbd_ptc_pkg::LFO_STEP_RST;
      base_q     <= bbd_ptc_pkg::BASE_PERIOD_RST;
      span_q     <= bbd_ptc_pkg::PERIOD_SPAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bbd_ptc_pkg::CFG_LFO_STEP:    lfo_step_q <= cfg_data_i;
        bbd_ptc_pkg::CFG_BASE_PERIOD: base_q     <= cfg_data_i[bbd_ptc_pkg::BASE_W-1:0];
        bbd_ptc_pkg::CFG_PERIOD_SPAN: span_q     <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // phase advance with single wrap
  logic signed [PW:0]   ph_sum, ph_wr;
  logic signed [PW-1:0] ph_new;
  logic [PW-1:0]        lfo_new;
  always_comb begin
    ph_sum  = $signed({phase_q[cidx_q][PW-1], phase_q[cidx_q]})
            + $signed({2'b00, lfo_step_q});
    ph_wr   = (ph_sum > PH_ONE) ? ph_sum - PH_TWO : ph_sum;
    ph_new  = ph_wr[PW-1:0];
    lfo_new = ph_new[PW-1] ? PW'(-ph_new) : PW'(ph_new);
  end

  // divisor and its magnitude
  logic signed [SPP_W-1:0] spp_rnd;
  logic signed [DW-1:0]    d_new;
  logic [DW-1:0]           d_abs;
  assign spp_rnd = spp_q + HALF_30;
  assign d_new   = $signed({{(DW - bbd_ptc_pkg::BASE_W){1'b0}}, base_q})
                 + $signed(spp_rnd[SPP_W-1:30]);
  assign d_abs   = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);

  // ring cell addressing
  logic [CELL_W-1:0] cell_idx, c0, c1, wp_next;
  logic [CELL_W:0]   c0s, c1s, wps;
  logic [FB-1:0]     frac;
  logic [ADDR_W-1:0] a0, a1, raddr;
  always_comb begin
    cell_idx = rp_q[cidx_q][RP_W-1:FB];
    frac     = rp_q[cidx_q][FB-1:0];
    c0s      = {1'b0, cell_idx} + (CELL_W + 1)'(bbd_ptc_pkg::READ_LEAD);
    c0       = (c0s >= (CELL_W + 1)'(RING_CELLS)) ? CELL_W'(c0s - (CELL_W + 1)'(RING_CELLS))
                                                 : c0s[CELL_W-1:0];
    c1s      = {1'b0, c0} + 1'b1;
    c1       = (c1s == (CELL_W + 1)'(RING_CELLS)) ? '0 : c1s[CELL_W-1:0];
    wps      = {1'b0, wp_q[cidx_q]} + 1'b1;
    wp_next  = (wps == (CELL_W + 1)'(RING_CELLS)) ? '0 : wps[CELL_W-1:0];
    a0       = addr_of(cidx_q, c0);
    a1       = addr_of(cidx_q, c1);
    raddr    = cmd_i.phase ? a0 : a1;
  end

  // interpolation terms
  logic signed [IP_W-1:0]   diff_s, diff_r;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [IPX_W-1:0]  ip_v, ip_sum_s, ip_sum_r;
  always_comb begin
    diff_s   = IP_W'(rs_q) - IP_W'(s0s_q);
    diff_r   = IP_W'(rr_q) - IP_W'(s0r_q);
    prod_rnd = prod_q + HALF_FB;
    ip_v     = prod_rnd[PROD_W-1:FB];
    ip_sum_s = IPX_W'(s0s_q) + ip_v;
    ip_sum_r = IPX_W'(s0r_q) + ip_v;
  end

  // divider operands
  logic          stored_pos;
  logic [RW-1:0] rate_abs;
  logic [QW-1:0] dvd;
  logic [DW-1:0] dvs;
  logic [QW-1:0] quo;
  logic          div_busy;
  assign stored_pos = !stored_q[RW-1] && (stored_q != '0);
  assign rate_abs   = rate_q[RW-1] ? RW'(-rate_q) : RW'(rate_q);
  always_comb begin
    if (cmd_i.rate_start) begin
      dvd = (QW'(1) << bbd_ptc_pkg::RATE_NUM_SHIFT) + QW'(d_abs >> 1);
      dvs = d_abs;
    end else begin
      dvd = (QW'(rate_abs) << FB) + QW'(stored_q[RW-1:1]);
      dvs = DW'(stored_q[RW-2:0]);
    end
  end

  bbd_ptc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rate_start | cmd_i.pitch_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // read position advance
  logic signed [RPX_W-1:0] rp_sum, rp_new;
  always_comb begin
    rp_sum = $signed({2'b00, rp_q[cidx_q]}) + RPX_W'(pitch_q);
    if (rp_sum >= RING_LEN)     rp_new = rp_sum - RING_LEN;
    else if (rp_sum < 0)        rp_new = rp_sum + RING_LEN;
    else                        rp_new = rp_sum;
  end

  // per-channel state, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        phase_q[i] <= '0;
        rp_q[i]    <= '0;
        wp_q[i]    <= '0;
      end
    end else begin
      if (cmd_i.phase) phase_q[cidx_q] <= ph_new;
      if (cmd_i.update) begin
        rp_q[cidx_q] <= rp_new[RP_W-1:0];
        wp_q[cidx_q] <= wp_next;
      end
    end
  end

  // clearing pass over both rings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clear && !clr_done_q) begin
      if (clr_q == ADDR_W'(DEPTH - 1)) clr_done_q <= 1'b1;
      else                             clr_q      <= clr_q + 1'b1;
    end
  end

  // ring write port
  logic                           we;
  logic [ADDR_W-1:0]              waddr;
  logic signed [SAMPLE_WIDTH-1:0] wd_s;
  logic signed [RW-1:0]           wd_r;
  always_comb begin
    if (cmd_i.clear && !clr_done_q) begin
      we    = 1'b1;
      waddr = clr_q;
      wd_s  = '0;
      wd_r  = '0;
    end else begin
      we    = cmd_i.update;
      waddr = addr_of(cidx_q, wp_next);
      wd_s  = sample_q;
      wd_r  = rate_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_s_q[waddr] <= wd_s;
      mem_r_q[waddr] <= wd_r;
    end
    if (cmd_i.phase || cmd_i.span) begin
      rs_q <= mem_s_q[raddr];
      rr_q <= mem_r_q[raddr];
    end
  end

  // item datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      chan_q   <= channel_i;
      cidx_q   <= (CHANNEL_COUNT > 1) ? CH_W'(channel_i) : '0;
      sample_q <= sample_in_i;
    end
    if (cmd_i.phase) lfo_q <= lfo_new;
    if (cmd_i.span) begin
      spp_q <= span_q * $signed({1'b0, lfo_q});
      s0s_q <= rs_q;
      s0r_q <= rr_q;
    end
    if (cmd_i.dvsr) d_q <= d_new;
    if (cmd_i.rate_take) begin
      rate_q <= (d_q == '0) ? bbd_ptc_pkg::Q420_MAX : sat_q(d_q[DW-1], quo);
    end
    if (cmd_i.ip_s) prod_q <= diff_s * $signed({1'b0, frac});
    if (cmd_i.ip_r) begin
      rd_q   <= ip_sum_s[SAMPLE_WIDTH-1:0];
      prod_q <= diff_r * $signed({1'b0, frac});
    end
    if (cmd_i.stored_take) stored_q <= ip_sum_r[RW-1:0];
    if (cmd_i.pitch_take) pitch_q <= stored_pos ? sat_q(rate_q[RW-1], quo) : rate_q;
    if (cmd_i.load_out) begin
      chan_out_q   <= chan_q;
      sample_out_q <= rd_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (!out_stall_i)  out_valid_q <= 1'b0;
  end

  assign sts_o.clear_done = clr_done_q;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.d_zero     = d_q == '0;
  assign sts_o.stored_pos = stored_pos;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = chan_out_q;
  assign sample_out_o  = sample_out_q;

endmodule
